// ===== design/i2cms_pkg.sv =====
package i2cms_pkg;

  localparam int BUFFER_DEPTH = 256;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  localparam logic REG_TARGET_ADDRESS = 1'b0;
  localparam logic REG_BYTE_COUNT     = 1'b1;

  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START_SENT  = 8'h08;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef struct packed {
    logic       command;
    logic [7:0] status_code;
    logic [7:0] rx_data;
    logic [7:0] tx_next;
  } req_t;

  typedef struct packed {
    logic       send_start;
    logic       clear_start;
    logic       ack_enable;
    logic       send_stop;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_data;
    logic [7:0] next_index;
    logic [7:0] bytes_left;
    logic       failed;
  } result_t;

  function automatic logic [7:0] advance_pos(input logic [7:0] p);
    logic [16:0] n;
    n = {9'd0, p} + 17'd1;
    if (n >= 17'(BUFFER_DEPTH)) begin
      return 8'd0;
    end
    return n[7:0];
  endfunction

endpackage

// ===== design/i2cms_core.sv =====
module i2cms_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                fire,
  input  i2cms_pkg::req_t     req,
  output i2cms_pkg::result_t res
);

  logic [7:0] target_address;
  logic [7:0] byte_count;
  logic [7:0] remaining;
  logic [7:0] position;
  logic       error_flag;
  logic [7:0] remaining_next;
  logic [7:0] position_next;
  logic       error_flag_next;
  logic [7:0] rem_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= 8'd0;
      byte_count     <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cms_pkg::REG_TARGET_ADDRESS: target_address <= cfg_data;
        i2cms_pkg::REG_BYTE_COUNT:     byte_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= 8'd0;
      position   <= 8'd0;
      error_flag <= 1'b0;
    end else if (fire) begin
      remaining  <= remaining_next;
      position   <= position_next;
      error_flag <= error_flag_next;
    end
  end

  always_comb begin
    rem_dec         = (remaining != 8'd0) ? remaining - 8'd1 : 8'd0;
    remaining_next  = remaining;
    position_next   = position;
    error_flag_next = error_flag;
    res             = '0;
    res.ack_enable  = 1'b1;
    if (req.command == i2cms_pkg::CMD_START) begin
      remaining_next  = byte_count;
      position_next   = 8'd0;
      error_flag_next = 1'b0;
      res.send_start  = 1'b1;
      res.ack_enable  = 1'b0;
    end else begin
      case (req.status_code)
        i2cms_pkg::ST_BUS_ERROR, i2cms_pkg::ST_ADDR_W_NACK,
        i2cms_pkg::ST_DATA_W_NACK, i2cms_pkg::ST_ADDR_R_NACK: begin
          res.send_stop   = 1'b1;
          error_flag_next = 1'b1;
          remaining_next  = 8'd0;
        end
        i2cms_pkg::ST_START_SENT: begin
          res.clear_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_data     = target_address;
          position_next   = 8'd0;
        end
        i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
          if (remaining != 8'd0) begin
            res.tx_valid   = 1'b1;
            res.tx_data    = req.tx_next;
            position_next  = i2cms_pkg::advance_pos(position);
            remaining_next = rem_dec;
          end else begin
            res.send_stop = 1'b1;
          end
        end
        i2cms_pkg::ST_ADDR_R_ACK: begin
          res.store_valid = 1'b1;
          res.store_data  = req.rx_data;
          position_next   = 8'd0;
          res.ack_enable  = (remaining != 8'd1);
        end
        i2cms_pkg::ST_DATA_R_ACK: begin
          res.store_valid = 1'b1;
          res.store_index = position;
          res.store_data  = req.rx_data;
          position_next   = i2cms_pkg::advance_pos(position);
          remaining_next  = rem_dec;
          res.ack_enable  = (rem_dec != 8'd0);
        end
        i2cms_pkg::ST_DATA_R_NACK: begin
          res.store_valid = 1'b1;
          res.store_index = position;
          res.store_data  = req.rx_data;
          position_next   = i2cms_pkg::advance_pos(position);
          remaining_next  = 8'd0;
          res.send_stop   = 1'b1;
        end
        default: ;
      endcase
    end
    res.next_index = position_next;
    res.bytes_left = remaining_next;
    res.failed     = error_flag_next;
  end

`ifndef NO_ASSERTIONS
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    fire && req.command == i2cms_pkg::CMD_START |=>
      error_flag == 1'b0 && position == 8'd0 && remaining == $past(byte_count))
    else $error("start request did not reload transfer state");

  a_remaining_no_rise: assert property (@(posedge clk) disable iff (rst)
    fire && req.command == i2cms_pkg::CMD_STATUS |=> remaining <= $past(remaining))
    else $error("remaining count rose on a status request");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_flag && !(fire && req.command == i2cms_pkg::CMD_START) |=> error_flag)
    else $error("error flag cleared without a start request");
`endif

endmodule

// ===== design/i2cms_out_buf.sv =====
module i2cms_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  i2cms_pkg::result_t  in_res,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cms_pkg::result_t  out_data
);

  logic               skid_valid;
  i2cms_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_res;
    end else if (in_fire) begin
      skid_data <= in_res;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && out_data == $past(skid_data))
    else $error("skid entry not moved to output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed before it was taken");
`endif

endmodule

// ===== design/i2c_master_transfer_sequencer.sv =====
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// request  | in_valid, in_ready, in_data      | in
// result   | out_valid, out_ready, out_data   | out
// config   | cfg_we, cfg_index, cfg_data      | in
//
// One request per cycle while in_ready is high; its result is registered in the output register or the skid entry.
// The state update and result decode take one pass through the status decoder.
// A two-entry output register/skid pair keeps in_ready high while one result waits.
// Reset clears the transfer state, configuration registers and both result slots.
// in_ready drops only while both result slots are full.
module i2c_master_transfer_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cms_pkg::req_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cms_pkg::result_t  out_data
);

  logic               fire;
  i2cms_pkg::result_t res;

  assign fire = in_valid && in_ready;

  i2cms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .req       (in_data),
    .res       (res)
  );

  i2cms_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (fire),
    .in_res    (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/i2c_master_transfer_sequencer_tb.sv =====
module i2c_master_transfer_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cms_pkg::*;

  localparam int LIMIT_CYCLES = 500000;

  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_RSVD_14   = 8'h14;
  localparam logic [7:0] ST_RSVD_FE   = 8'hfe;

  localparam logic [7:0] KNOWN_CODES [13] = '{
    ST_BUS_ERROR, ST_START_SENT, ST_ADDR_W_ACK, ST_ADDR_W_NACK, ST_DATA_W_ACK,
    ST_DATA_W_NACK, ST_ADDR_R_ACK, ST_ADDR_R_NACK, ST_DATA_R_ACK, ST_DATA_R_NACK,
    ST_REP_START, ST_RSVD_14, ST_RSVD_FE
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_TARGET_ADDRESS;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  result_t    out_data;

  // predictor state and its copy of the registers
  logic [7:0] cfg_addr = 8'd0;
  logic [7:0] cfg_count = 8'd0;
  logic [7:0] left_cnt = 8'd0;
  logic [7:0] buf_pos = 8'd0;
  logic       err_seen = 1'b0;

  result_t pending_actions[$];

  int fail_cnt = 0;
  int sent_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int noise_pct = 0;
  int hold_cycles = 0;

  i2c_master_transfer_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] step_pos(input logic [7:0] p);
    logic [8:0] n;
    n = {1'b0, p} + 9'd1;
    return (n >= 9'(BUFFER_DEPTH)) ? 8'd0 : n[7:0];
  endfunction

  function automatic result_t next_bus_action(input req_t r);
    result_t a;
    a = '0;
    a.ack_enable = 1'b1;
    if (r.command == CMD_START) begin
      left_cnt = cfg_count;
      buf_pos = 8'd0;
      err_seen = 1'b0;
      a.send_start = 1'b1;
      a.ack_enable = 1'b0;
    end else begin
      case (r.status_code)
        ST_BUS_ERROR, ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
          a.send_stop = 1'b1;
          err_seen = 1'b1;
          left_cnt = 8'd0;
        end
        ST_START_SENT: begin
          a.clear_start = 1'b1;
          a.tx_valid = 1'b1;
          a.tx_data = cfg_addr;
          buf_pos = 8'd0;
        end
        ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
          if (left_cnt != 8'd0) begin
            a.tx_valid = 1'b1;
            a.tx_data = r.tx_next;
            buf_pos = step_pos(buf_pos);
            left_cnt = left_cnt - 8'd1;
          end else begin
            a.send_stop = 1'b1;
          end
        end
        ST_ADDR_R_ACK: begin
          a.store_valid = 1'b1;
          a.store_data = r.rx_data;
          buf_pos = 8'd0;
          if (left_cnt == 8'd1) begin
            a.ack_enable = 1'b0;
          end
        end
        ST_DATA_R_ACK: begin
          a.store_valid = 1'b1;
          a.store_index = buf_pos;
          a.store_data = r.rx_data;
          buf_pos = step_pos(buf_pos);
          if (left_cnt != 8'd0) begin
            left_cnt = left_cnt - 8'd1;
          end
          if (left_cnt == 8'd0) begin
            a.ack_enable = 1'b0;
          end
        end
        ST_DATA_R_NACK: begin
          a.store_valid = 1'b1;
          a.store_index = buf_pos;
          a.store_data = r.rx_data;
          buf_pos = step_pos(buf_pos);
          left_cnt = 8'd0;
          a.send_stop = 1'b1;
        end
        default: begin
        end
      endcase
    end
    a.next_index = buf_pos;
    a.bytes_left = left_cnt;
    a.failed = err_seen;
    return a;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_actions.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = pending_actions.pop_front();
        compare_field("send_start", 8'(want.send_start), 8'(out_data.send_start));
        compare_field("clear_start", 8'(want.clear_start), 8'(out_data.clear_start));
        compare_field("ack_enable", 8'(want.ack_enable), 8'(out_data.ack_enable));
        compare_field("send_stop", 8'(want.send_stop), 8'(out_data.send_stop));
        compare_field("tx_valid", 8'(want.tx_valid), 8'(out_data.tx_valid));
        compare_field("tx_data", want.tx_data, out_data.tx_data);
        compare_field("store_valid", 8'(want.store_valid), 8'(out_data.store_valid));
        compare_field("store_index", want.store_index, out_data.store_index);
        compare_field("store_data", want.store_data, out_data.store_data);
        compare_field("next_index", want.next_index, out_data.next_index);
        compare_field("bytes_left", want.bytes_left, out_data.bytes_left);
        compare_field("failed", 8'(want.failed), 8'(out_data.failed));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input req_t r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    pending_actions.push_back(next_bus_action(r));
    sent_cnt++;
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] code,
                           input logic [7:0] rx, input logic [7:0] tx);
    req_t r;
    r.command = cmd;
    r.status_code = code;
    r.rx_data = rx;
    r.tx_next = tx;
    send_request(r);
  endtask

  task automatic send_start_cmd();
    send_item(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] noise_code();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return KNOWN_CODES[4'($urandom_range(10, 12))];
      default: return KNOWN_CODES[4'($urandom_range(12))];
    endcase
  endfunction

  // occasionally swap in a stray code or an early restart
  task automatic send_status(input logic [7:0] code);
    int roll;
    roll = $urandom_range(99);
    if (roll < noise_pct) begin
      send_item(CMD_STATUS, noise_code(), 8'($urandom), 8'($urandom));
    end else if (noise_pct > 0 && roll < noise_pct + 3) begin
      send_start_cmd();
    end else begin
      send_item(CMD_STATUS, code, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [7:0] addr, input logic [7:0] cnt);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_TARGET_ADDRESS;
    cfg_data <= addr;
    @(negedge clk);
    cfg_index <= REG_BYTE_COUNT;
    cfg_data <= cnt;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_addr = addr;
    cfg_count = cnt;
  endtask

  function automatic logic [7:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 8'd0;
    if (roll < 9) return 8'd255;
    if (roll < 16) return 8'd1;
    return 8'($urandom_range(2, 8));
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_transfer();
    int data_cnt;
    if ($urandom_range(99) < 35) begin
      load_config(pick_addr(), pick_count());
    end
    data_cnt = (cfg_count > 8'd12) ? 12 : int'(cfg_count);
    send_start_cmd();
    send_status(ST_START_SENT);
    if (!cfg_addr[0]) begin
      if ($urandom_range(99) < 6) begin
        send_status(ST_ADDR_W_NACK);
      end else begin
        send_status(ST_ADDR_W_ACK);
        for (int k = 1; k < data_cnt; k++) begin
          send_status(ST_DATA_W_ACK);
        end
        send_status(($urandom_range(99) < 8) ? ST_DATA_W_NACK : ST_DATA_W_ACK);
        send_status(ST_DATA_W_ACK);
      end
    end else begin
      if ($urandom_range(99) < 6) begin
        send_status(ST_ADDR_R_NACK);
      end else begin
        send_status(ST_ADDR_R_ACK);
        for (int k = 1; k < data_cnt; k++) begin
          send_status(ST_DATA_R_ACK);
        end
        send_status(ST_DATA_R_NACK);
      end
    end
  endtask

  task automatic run_transfers(input int n);
    int first;
    first = sent_cnt;
    while (sent_cnt - first < n) begin
      run_transfer();
    end
  endtask

  task automatic test_write_transfer();
    load_config(8'ha4, 8'd2);
    send_item(CMD_START, 8'hff, 8'hff, 8'hff);
    send_item(CMD_STATUS, ST_START_SENT, 8'h00, 8'h00);
    send_item(CMD_STATUS, ST_ADDR_W_ACK, 8'h00, 8'hff);
    send_item(CMD_STATUS, ST_DATA_W_ACK, 8'hff, 8'h00);
    send_item(CMD_STATUS, ST_DATA_W_ACK, 8'h5a, 8'ha5);
  endtask

  task automatic test_error_codes();
    send_item(CMD_STATUS, ST_BUS_ERROR, 8'h12, 8'h34);
    send_item(CMD_START, 8'h00, 8'h00, 8'h00);
    send_item(CMD_STATUS, ST_ADDR_W_NACK, 8'h56, 8'h78);
    send_item(CMD_STATUS, ST_DATA_W_NACK, 8'h9a, 8'hbc);
    send_item(CMD_STATUS, ST_ADDR_R_NACK, 8'hde, 8'hf0);
  endtask

  task automatic test_read_transfer();
    load_config(8'hff, 8'd1);
    send_start_cmd();
    send_item(CMD_STATUS, ST_START_SENT, 8'h00, 8'h00);
    send_item(CMD_STATUS, ST_ADDR_R_ACK, 8'h3c, 8'h00);
    send_item(CMD_STATUS, ST_DATA_R_NACK, 8'hff, 8'h00);
    send_item(CMD_STATUS, ST_DATA_R_ACK, 8'h00, 8'hff);
  endtask

  task automatic test_empty_and_unknown();
    load_config(8'h00, 8'd0);
    send_start_cmd();
    send_item(CMD_STATUS, ST_ADDR_W_ACK, 8'h11, 8'h22);
    send_item(CMD_STATUS, ST_REP_START, 8'h33, 8'h44);
    send_item(CMD_STATUS, ST_RSVD_14, 8'h55, 8'h66);
    send_item(CMD_STATUS, ST_RSVD_FE, 8'h77, 8'h88);
    send_item(CMD_STATUS, 8'hff, 8'h99, 8'haa);
  endtask

  // long read so the count saturates and the position wraps
  task automatic test_long_read();
    load_config(8'($urandom) | 8'h01, 8'd255);
    send_start_cmd();
    send_status(ST_START_SENT);
    send_status(ST_ADDR_R_ACK);
    repeat (257) send_status(ST_DATA_R_ACK);
    send_status(ST_DATA_R_NACK);
  endtask

  task automatic test_random_phases();
    noise_pct = 10;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_transfers(200);
    send_idle_pct = 79;
    recv_stall_pct = 0;
    run_transfers(200);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    run_transfers(200);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    run_transfers(200);
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 60;
    run_transfers(70);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_write_transfer();
    test_error_codes();
    test_read_transfer();
    test_empty_and_unknown();
    test_long_read();
    test_random_phases();
    test_backpressure();
    drain_results();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/i2cms_pkg.sv
design/i2cms_core.sv
design/i2cms_out_buf.sv
design/i2c_master_transfer_sequencer.sv
tb/sv/i2c_master_transfer_sequencer_tb.sv
